// ----- rtl/fba_pkg.sv -----
// Shared types and constants for the frame bitmap allocator.
// Holds the payload structs, operation codes, sequencer states and control structs.
// It has no dependencies.
package fba_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned COUNT_W     = 13;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BIT_W       = 5;
  localparam int unsigned FRAME_SHIFT = 12;
  localparam int unsigned LIMIT_W     = 21;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_INIT  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_FILL
  } state_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ADDR_W-1:0] frame_address;
  } fba_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  alloc_address;
    logic               out_of_memory;
    logic [COUNT_W-1:0] free_count;
    logic [COUNT_W-1:0] used_count_out;
  } fba_out_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic       accept;
    logic [1:0] mode;
    logic       free_ok;
    logic       word_full;
    logic       bit_set;
    logic       ptr_last;
    logic       pend;
    logic       pend_last;
  } fba_stat_t;

  // Controls from the sequencer to the datapath.
  typedef struct packed {
    logic busy;
    logic rd_en;
    logic wr_fill;
    logic wr_alloc;
    logic wr_free;
    logic ptr_load;
    logic ptr_inc;
    logic cnt_inc;
    logic cnt_dec;
    logic cnt_load;
    logic done;
    logic oom;
  } fba_ctrl_t;

endpackage

// ----- rtl/frame_bitmap_allocator.sv -----
// Top level of the first-fit physical frame allocator.
// Depends on fba_pkg, fba_ram, fba_word_unit and fba_seq.

// The allocator keeps one used bit per 4 KiB frame in a RAM of 32-bit words
// (NUM_FRAMES/32 words, rounded up) plus a count of used frames. A transaction
// is accepted when start is high and busy is low; every transaction returns
// exactly one result, shown for one cycle with done_o high, and the receiver
// must take it then. Allocate scans the map one word per cycle through the
// single RAM read port and stops at the first word with a free frame, or at
// the last word, which is the out-of-memory case. Reinitialize writes one
// word per cycle. Free reads the map word, then modifies and writes it back;
// a free whose address lies outside memory, and mode three, are answered
// without touching the map. After reset the block runs a clearing pass over
// the map, one word per cycle, and holds busy high meanwhile. The reserved end
// register may be written at any time the block is idle; it is sampled when a
// reinitialize transaction is accepted. Frame zero is a valid allocation and
// returns address 0 with out_of_memory low.
module frame_bitmap_allocator import fba_pkg::*; #(
  parameter int unsigned NUM_FRAMES = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  fba_in_t           in_i,
  output logic              done_o,
  output fba_out_t          result_o,
  input  logic              cfg_we_i,
  input  logic [ADDR_W-1:0] cfg_wdata_i
);

  localparam int unsigned WORDS = (NUM_FRAMES + WORD_W - 1) / WORD_W;
  localparam int unsigned WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_FRAMES + 1);
  localparam logic [WAW-1:0]     LAST      = WAW'(WORDS - 1);
  localparam logic [LIMIT_W-1:0] NUM_LIMIT = LIMIT_W'(NUM_FRAMES);
  localparam logic [ADDR_W-1:0]  NUM_ADDR  = ADDR_W'(NUM_FRAMES);

  fba_ctrl_t ctrl;
  fba_stat_t stat;

  logic [ADDR_W-1:0] reserved_end_q;
  logic [WAW-1:0]    ptr_q, ptr_d;
  logic [WAW-1:0]    pend_addr_q;
  logic              pend_q;
  logic [BIT_W-1:0]  bit_q;
  logic [CNT_W-1:0]  limit_q;
  logic [CNT_W-1:0]  used_q, used_d;
  logic              done_q;
  logic [ADDR_W-1:0] res_addr_q;
  logic              res_oom_q;

  logic                    accept;
  logic [ADDR_W-FRAME_SHIFT-1:0] in_frame;
  logic                    free_ok;
  logic [WAW-1:0]          free_word;
  logic [ADDR_W:0]         ceil_sum;
  logic [LIMIT_W-1:0]      ceil_frames;
  logic [LIMIT_W-1:0]      limit_new;

  logic              ram_we;
  logic [WAW-1:0]    ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] fill_word;
  logic              word_full;
  logic [BIT_W-1:0]  zero_idx;
  logic [WORD_W-1:0] alloc_word;
  logic [WORD_W-1:0] free_word_data;
  logic [ADDR_W-1:0] alloc_addr;
  logic [ADDR_W-1:0] free_cnt32;
  logic [ADDR_W-1:0] used_cnt32;

  assign accept = start && !ctrl.busy;
  assign busy   = ctrl.busy;

  // Decode of an incoming free request and of the reserved frame limit.
  assign in_frame  = in_i.frame_address[ADDR_W-1:FRAME_SHIFT];
  assign free_ok   = ({1'b0, in_frame} < NUM_LIMIT);
  assign free_word = WAW'(in_frame >> BIT_W);

  always_comb begin
    ceil_sum    = {1'b0, reserved_end_q} + (ADDR_W + 1)'((1 << FRAME_SHIFT) - 1);
    ceil_frames = ceil_sum[ADDR_W:FRAME_SHIFT];
    limit_new   = (ceil_frames > NUM_LIMIT) ? NUM_LIMIT : ceil_frames;
  end

  always_comb begin
    stat           = '0;
    stat.accept    = accept;
    stat.mode      = in_i.mode;
    stat.free_ok   = free_ok;
    stat.word_full = word_full;
    stat.bit_set   = ram_rdata[bit_q];
    stat.ptr_last  = (ptr_q == LAST);
    stat.pend      = pend_q;
    stat.pend_last = (pend_addr_q == LAST);
  end

  fba_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  fba_word_unit #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_word_unit (
    .widx_i     (ptr_q),
    .limit_i    (limit_q),
    .rdata_i    (ram_rdata),
    .fill_o     (fill_word),
    .full_o     (word_full),
    .zero_idx_o (zero_idx)
  );

  // Map word updates: a fill pattern during clear and init, one bit set on
  // allocate, one bit cleared on free.
  assign alloc_word     = ram_rdata | (WORD_W'(1) << zero_idx);
  assign free_word_data = ram_rdata & ~(WORD_W'(1) << bit_q);

  always_comb begin
    ram_we    = ctrl.wr_fill || ctrl.wr_alloc || ctrl.wr_free;
    ram_waddr = ctrl.wr_alloc ? pend_addr_q : ptr_q;
    priority if (ctrl.wr_fill) begin
      ram_wdata = fill_word;
    end else if (ctrl.wr_alloc) begin
      ram_wdata = alloc_word;
    end else begin
      ram_wdata = free_word_data;
    end
  end

  fba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ctrl.rd_en),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  // Word pointer: loaded on acceptance, stepped during scans and sweeps, and
  // parked on the last word.
  always_comb begin
    ptr_d = ptr_q;
    if (ctrl.ptr_load) begin
      ptr_d = (in_i.mode == MODE_FREE) ? free_word : '0;
    end else if (ctrl.ptr_inc && (ptr_q != LAST)) begin
      ptr_d = ptr_q + WAW'(1);
    end
  end

  always_comb begin
    used_d = used_q;
    priority if (ctrl.cnt_load) begin
      used_d = limit_q;
    end else if (ctrl.cnt_inc) begin
      used_d = used_q + CNT_W'(1);
    end else if (ctrl.cnt_dec) begin
      used_d = used_q - CNT_W'(1);
    end
  end

  assign alloc_addr = (ADDR_W'(pend_addr_q) << (BIT_W + FRAME_SHIFT))
                    | (ADDR_W'(zero_idx) << FRAME_SHIFT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_end_q <= '0;
      ptr_q          <= '0;
      pend_q         <= 1'b0;
      limit_q        <= '0;
      used_q         <= '0;
      done_q         <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        reserved_end_q <= cfg_wdata_i;
      end
      if (accept && in_i.mode == MODE_INIT) begin
        limit_q <= CNT_W'(limit_new);
      end
      ptr_q  <= ptr_d;
      pend_q <= ctrl.rd_en;
      used_q <= used_d;
      done_q <= ctrl.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.rd_en) begin
      pend_addr_q <= ptr_q;
    end
    if (ctrl.ptr_load) begin
      bit_q <= in_i.frame_address[FRAME_SHIFT+BIT_W-1:FRAME_SHIFT];
    end
    if (ctrl.done) begin
      res_addr_q <= ctrl.wr_alloc ? alloc_addr : '0;
      res_oom_q  <= ctrl.oom;
    end
  end

  // The counts follow the used total, which is already updated in the
  // cycle that carries the result.
  assign free_cnt32 = NUM_ADDR - ADDR_W'(used_q);
  assign used_cnt32 = ADDR_W'(used_q);

  assign done_o                  = done_q;
  assign result_o.alloc_address  = res_addr_q;
  assign result_o.out_of_memory  = res_oom_q;
  assign result_o.free_count     = free_cnt32[COUNT_W-1:0];
  assign result_o.used_count_out = used_cnt32[COUNT_W-1:0];

  // A failed allocation never reports an address.
  a_oom_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.out_of_memory |-> result_o.alloc_address == '0)
    else $error("out_of_memory result with a nonzero address");

  // The used total never exceeds the number of frames.
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(NUM_FRAMES))
    else $error("used frame count beyond memory size");

  // Every accepted transaction either keeps the block busy or answers at once.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || done_o)
    else $error("accepted transaction neither busy nor answered");

  // A map write on allocate always raises the used count by one.
  a_alloc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.wr_alloc |=> used_q == $past(used_q) + CNT_W'(1))
    else $error("allocation did not bump the used count");

endmodule

// ----- rtl/fba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/fba_word_unit.sv -----
// Word-level arithmetic for the allocator: fill pattern of one map word and the
// lowest clear bit of a word read from the map. Depends on fba_pkg.
module fba_word_unit import fba_pkg::*; #(
  parameter int unsigned NUM_FRAMES = 4096,
  localparam int unsigned WORDS = (NUM_FRAMES + WORD_W - 1) / WORD_W,
  localparam int unsigned WAW   = (WORDS > 1) ? $clog2(WORDS) : 1,
  localparam int unsigned CNT_W = $clog2(NUM_FRAMES + 1)
) (
  input  logic [WAW-1:0]    widx_i,
  input  logic [CNT_W-1:0]  limit_i,
  input  logic [WORD_W-1:0] rdata_i,
  output logic [WORD_W-1:0] fill_o,
  output logic              full_o,
  output logic [BIT_W-1:0]  zero_idx_o
);

  // Frames past the end of memory in the last word always read as used.
  localparam int unsigned REM = NUM_FRAMES - (WORDS - 1) * WORD_W;
  localparam logic [WORD_W-1:0] PAD_MASK = ~({WORD_W{1'b1}} >> (WORD_W - REM));
  localparam logic [WAW-1:0] LAST = WAW'(WORDS - 1);

  logic [LIMIT_W:0]  base;
  logic [LIMIT_W:0]  top;
  logic [LIMIT_W:0]  lim;
  logic [LIMIT_W:0]  diff;
  logic [WORD_W-1:0] pattern;

  always_comb begin
    base = (LIMIT_W + 1)'(widx_i) << BIT_W;
    top  = base + (LIMIT_W + 1)'(WORD_W);
    lim  = (LIMIT_W + 1)'(limit_i);
    diff = lim - base;
    if (lim >= top) begin
      pattern = {WORD_W{1'b1}};
    end else if (lim <= base) begin
      pattern = '0;
    end else begin
      pattern = ~({WORD_W{1'b1}} << diff[BIT_W-1:0]);
    end
    fill_o = (widx_i == LAST) ? (pattern | PAD_MASK) : pattern;
  end

  always_comb begin
    full_o     = &rdata_i;
    zero_idx_o = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!rdata_i[i]) begin
        zero_idx_o = BIT_W'(i);
      end
    end
  end

endmodule

// ----- rtl/fba_seq.sv -----
// Sequencer of the allocator: clearing pass, word scan, free read-modify-write and init sweep.
// Depends on fba_pkg.
module fba_seq import fba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  fba_stat_t stat_i,
  output fba_ctrl_t ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (stat_i.ptr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (stat_i.accept) begin
          unique case (stat_i.mode)
            MODE_ALLOC: state_d = ST_SCAN;
            MODE_FREE:  state_d = stat_i.free_ok ? ST_FREE_RD : ST_IDLE;
            MODE_INIT:  state_d = ST_FILL;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (stat_i.pend && (!stat_i.word_full || stat_i.pend_last)) state_d = ST_IDLE;
      end
      ST_FREE_RD: state_d = ST_FREE_WR;
      ST_FREE_WR: state_d = ST_IDLE;
      ST_FILL: begin
        if (stat_i.ptr_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o      = '0;
    ctrl_o.busy = (state_q != ST_IDLE);
    unique case (state_q)
      ST_CLEAR: begin
        ctrl_o.wr_fill = 1'b1;
        ctrl_o.ptr_inc = 1'b1;
      end
      ST_IDLE: begin
        if (stat_i.accept) begin
          ctrl_o.ptr_load = 1'b1;
          if (stat_i.mode == MODE_NOP || (stat_i.mode == MODE_FREE && !stat_i.free_ok)) begin
            ctrl_o.done = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        ctrl_o.rd_en   = 1'b1;
        ctrl_o.ptr_inc = 1'b1;
        if (stat_i.pend) begin
          if (!stat_i.word_full) begin
            ctrl_o.wr_alloc = 1'b1;
            ctrl_o.cnt_inc  = 1'b1;
            ctrl_o.done     = 1'b1;
          end else if (stat_i.pend_last) begin
            ctrl_o.done = 1'b1;
            ctrl_o.oom  = 1'b1;
          end
        end
      end
      ST_FREE_RD: begin
        ctrl_o.rd_en = 1'b1;
      end
      ST_FREE_WR: begin
        ctrl_o.done = 1'b1;
        if (stat_i.bit_set) begin
          ctrl_o.wr_free = 1'b1;
          ctrl_o.cnt_dec = 1'b1;
        end
      end
      ST_FILL: begin
        ctrl_o.wr_fill = 1'b1;
        ctrl_o.ptr_inc = 1'b1;
        if (stat_i.ptr_last) begin
          ctrl_o.cnt_load = 1'b1;
          ctrl_o.done     = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
